### sv/css_terminator_scanner_defines.svh
// Assertion macros used by the checker file of the terminator scanner.
`ifndef CSS_TERMINATOR_SCANNER_DEFINES_SVH
`define CSS_TERMINATOR_SCANNER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define CSS_TS_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define CSS_TS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define CSS_TS_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/css_ts_pkg.sv
package css_ts_pkg;

   localparam int STACK_ENTRIES_DEFAULT   = 128;
   localparam int POSITION_BITS_DEFAULT   = 16;
   localparam int MAX_TERMINATORS_DEFAULT = 4;

   localparam int BYTE_BITS       = 8;
   localparam int NEST_BITS       = 8;
   localparam int TERM_COUNT_BITS = 3;
   localparam int CFG_TERMS       = 4;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 8;
   localparam int REQ_DATA_BITS   = 24;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_LSQUARE   = 8'h5B;
   localparam logic [7:0] CHAR_RSQUARE   = 8'h5D;
   localparam logic [7:0] CHAR_LCURLY    = 8'h7B;
   localparam logic [7:0] CHAR_RCURLY    = 8'h7D;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;

   localparam logic [7:0] TERM_CHAR_A_RESET = 8'd59;
   localparam logic [2:0] TERM_COUNT_RESET  = 3'd1;

   typedef enum logic [2:0] {
      CSR_TERM_COUNT = 3'd0,
      CSR_TERM_A     = 3'd1,
      CSR_TERM_B     = 3'd2,
      CSR_TERM_C     = 3'd3,
      CSR_TERM_D     = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_DOUBLE = 2'd1,
      QUOTE_SINGLE = 2'd2
   } quote_type;

   typedef enum logic [1:0] {
      CLOSER_NONE   = 2'd0,
      CLOSER_PAREN  = 2'd1,
      CLOSER_SQUARE = 2'd2,
      CLOSER_CURLY  = 2'd3
   } closer_type;

   // One update of the bracket stack for the item being processed.
   typedef struct packed {
      logic       clear;
      logic       push;
      logic       pop;
      closer_type code;
   } stack_op_type;

   typedef struct packed {
      logic       start;
      logic       ahead_valid;
      logic [7:0] ahead;
      logic [7:0] text;
   } scan_item_type;

   function automatic closer_type closer_of(input logic [7:0] c);
      closer_type code;
      code = CLOSER_NONE;
      if (c == CHAR_RPAREN) code = CLOSER_PAREN;
      else if (c == CHAR_RSQUARE) code = CLOSER_SQUARE;
      else if (c == CHAR_RCURLY) code = CLOSER_CURLY;
      return code;
   endfunction

   function automatic closer_type opener_of(input logic [7:0] c);
      closer_type code;
      code = CLOSER_NONE;
      if (c == CHAR_LPAREN) code = CLOSER_PAREN;
      else if (c == CHAR_LSQUARE) code = CLOSER_SQUARE;
      else if (c == CHAR_LCURLY) code = CLOSER_CURLY;
      return code;
   endfunction

endpackage

### sv/css_ts_stack.sv
module css_ts_stack #(
   parameter int ENTRIES = css_ts_pkg::STACK_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  css_ts_pkg::stack_op_type     op,
   output logic [$clog2(ENTRIES+1)-1:0] depth,
   output css_ts_pkg::closer_type       top
);

   localparam int DEPTH_BITS = $clog2(ENTRIES + 1);
   localparam int ADDR_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [DEPTH_BITS-1:0]  depth_ff;
   logic [DEPTH_BITS-1:0]  depth_in;
   logic [DEPTH_BITS-1:0]  base;
   logic [DEPTH_BITS-1:0]  below;
   css_ts_pkg::closer_type top_ff;
   css_ts_pkg::closer_type mem [ENTRIES];

   always_comb begin
      base  = op.clear ? '0 : depth_ff;
      below = base - DEPTH_BITS'(2);
      priority if (op.push) begin
         depth_in = base + DEPTH_BITS'(1);
      end else if (op.pop) begin
         depth_in = base - DEPTH_BITS'(1);
      end else begin
         depth_in = base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else if (enable) begin
         depth_ff <= depth_in;
      end
   end

   // The memory holds every entry; the top entry is also kept in a register so
   // that the next item can compare against it at once. After a pop the new
   // top is read from the entry two below the old depth.
   always_ff @(posedge clock) begin
      if (enable && op.push) begin
         mem[base[ADDR_BITS-1:0]] <= op.code;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (op.push) begin
            top_ff <= op.code;
         end else if (op.pop && (base > DEPTH_BITS'(1))) begin
            top_ff <= mem[below[ADDR_BITS-1:0]];
         end
      end
   end

   assign depth = depth_ff;
   assign top   = top_ff;

endmodule

### sv/css_terminator_scanner.sv
// CSS terminator scanner.
// Items arrive on the req_ stream, one text byte each, with the byte that
// follows it, a flag saying whether that byte exists, and on req_tuser a
// flag that starts a new scan and clears all scan state first. Each item gives
// exactly one item on the rsp_ stream: a hit flag, the terminator byte found,
// the byte's offset from scan start (saturating) and the bracket depth after
// the byte. Terminator bytes are set through the csr_ write channel, which is
// always ready; it must be written only while the block is idle, which the
// block itself does not enforce. rsp_tvalid rises once the input register has
// taken the item and the scan logic has filled the result register. One item
// is taken every cycle while the receiver does not stall; the rate is set by
// the top-of-stack register, loaded in the same cycle as each push or pop.
// When the receiver stalls, the held result stays and one more item waits in
// the input register; req_tready drops only while both are full.
// Reset empties both registers, restores the terminator defaults and clears
// the scan state. The bracket memory is never cleared: only entries below the
// current depth are ever read.
module css_terminator_scanner #(
   parameter int STACK_ENTRIES   = css_ts_pkg::STACK_ENTRIES_DEFAULT,
   parameter int POSITION_BITS   = css_ts_pkg::POSITION_BITS_DEFAULT,
   parameter int MAX_TERMINATORS = css_ts_pkg::MAX_TERMINATORS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // text_byte [7:0], ahead_byte [15:8], ahead_valid [16], zero fill above
   input  logic [css_ts_pkg::REQ_DATA_BITS-1:0]      req_tdata,
   // scan_start
   input  logic                                      req_tuser,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // hit [0], hit_char [8:1], position, nest_level, zero fill above
   output logic [((POSITION_BITS+17+7)/8)*8-1:0]     rsp_tdata,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [css_ts_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [css_ts_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   localparam int DEPTH_BITS = $clog2(STACK_ENTRIES + 1);
   localparam int RSP_BITS   = ((POSITION_BITS + 17 + 7) / 8) * 8;

   // Configuration.
   logic [css_ts_pkg::TERM_COUNT_BITS-1:0] term_count_ff;
   logic [7:0]                             term_char_ff [css_ts_pkg::CFG_TERMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff   <= css_ts_pkg::TERM_COUNT_RESET;
         term_char_ff[0] <= css_ts_pkg::TERM_CHAR_A_RESET;
         term_char_ff[1] <= '0;
         term_char_ff[2] <= '0;
         term_char_ff[3] <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (css_ts_pkg::csr_index_type'(csr_index))
            css_ts_pkg::CSR_TERM_COUNT: term_count_ff <= csr_data[2:0];
            css_ts_pkg::CSR_TERM_A:     term_char_ff[0] <= csr_data;
            css_ts_pkg::CSR_TERM_B:     term_char_ff[1] <= csr_data;
            css_ts_pkg::CSR_TERM_C:     term_char_ff[2] <= csr_data;
            css_ts_pkg::CSR_TERM_D:     term_char_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Input register and result register.
   logic                      s1_valid_ff;
   css_ts_pkg::scan_item_type s1_ff;
   logic                      rsp_valid_ff;
   logic [RSP_BITS-1:0]       rsp_data_ff;
   logic                      advance;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_ff.text        <= req_tdata[7:0];
         s1_ff.ahead       <= req_tdata[15:8];
         s1_ff.ahead_valid <= req_tdata[16];
         s1_ff.start       <= req_tuser;
      end
   end

   // Scan state.
   css_ts_pkg::quote_type    quote_ff, quote_in;
   logic                     comment_ff, comment_in;
   logic                     skip_ff, skip_in;
   logic [POSITION_BITS-1:0] offset_ff, offset_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff   <= css_ts_pkg::QUOTE_NONE;
         comment_ff <= 1'b0;
         skip_ff    <= 1'b0;
         offset_ff  <= '0;
      end else if (advance) begin
         quote_ff   <= quote_in;
         comment_ff <= comment_in;
         skip_ff    <= skip_in;
         offset_ff  <= offset_in;
      end
   end

   css_ts_pkg::stack_op_type stack_op;
   logic [DEPTH_BITS-1:0]    stack_depth;
   css_ts_pkg::closer_type   stack_top;

   css_ts_stack #(
      .ENTRIES (STACK_ENTRIES)
   ) u_stack (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .op     (stack_op),
      .depth  (stack_depth),
      .top    (stack_top)
   );

   logic [7:0]               c;
   logic                     look_star;
   logic                     look_slash;
   logic [DEPTH_BITS-1:0]    eff_depth;
   logic [DEPTH_BITS-1:0]    new_depth;
   logic [31:0]              depth_wide;
   logic [POSITION_BITS-1:0] pos;
   logic                     is_term;
   logic                     hit;
   logic [7:0]               hit_char;
   logic [7:0]               nest;
   css_ts_pkg::closer_type   close_code;
   logic [7:0]               quote_char;

   always_comb begin
      c          = s1_ff.text;
      look_star  = s1_ff.ahead_valid && (s1_ff.ahead == css_ts_pkg::CHAR_STAR);
      look_slash = s1_ff.ahead_valid && (s1_ff.ahead == css_ts_pkg::CHAR_SLASH);
      close_code = css_ts_pkg::closer_of(c);

      // A start item sees the cleared state.
      eff_depth  = s1_ff.start ? '0 : stack_depth;
      pos        = s1_ff.start ? '0 : offset_ff;
      quote_in   = s1_ff.start ? css_ts_pkg::QUOTE_NONE : quote_ff;
      comment_in = s1_ff.start ? 1'b0 : comment_ff;
      skip_in    = s1_ff.start ? 1'b0 : skip_ff;
      offset_in  = (pos != '1) ? pos + POSITION_BITS'(1) : pos;
      quote_char = (quote_in == css_ts_pkg::QUOTE_DOUBLE) ? css_ts_pkg::CHAR_DQUOTE
                                                          : css_ts_pkg::CHAR_SQUOTE;

      is_term = (c == css_ts_pkg::CHAR_NUL);
      for (int i = 0; i < css_ts_pkg::CFG_TERMS; i++) begin
         if ((i < MAX_TERMINATORS) && (32'(term_count_ff) > i) && (term_char_ff[i] == c)) begin
            is_term = 1'b1;
         end
      end

      stack_op       = '0;
      stack_op.clear = s1_ff.start;
      stack_op.code  = css_ts_pkg::opener_of(c);
      hit            = 1'b0;
      hit_char       = '0;

      priority if (skip_in) begin
         skip_in = 1'b0;
      end else if (comment_in) begin
         if (c == css_ts_pkg::CHAR_STAR && look_slash) begin
            comment_in = 1'b0;
            skip_in    = 1'b1;
         end
      end else if (quote_in != css_ts_pkg::QUOTE_NONE) begin
         if (c == css_ts_pkg::CHAR_BACKSLASH && s1_ff.ahead_valid) begin
            skip_in = 1'b1;
         end else if (c == quote_char) begin
            quote_in = css_ts_pkg::QUOTE_NONE;
         end
      end else if (c == css_ts_pkg::CHAR_SLASH && look_star) begin
         comment_in = 1'b1;
         skip_in    = 1'b1;
      end else if (c == css_ts_pkg::CHAR_BACKSLASH && s1_ff.ahead_valid) begin
         skip_in = 1'b1;
      end else if (c == css_ts_pkg::CHAR_DQUOTE) begin
         quote_in = css_ts_pkg::QUOTE_DOUBLE;
      end else if (c == css_ts_pkg::CHAR_SQUOTE) begin
         quote_in = css_ts_pkg::QUOTE_SINGLE;
      end else if (eff_depth == '0 && is_term) begin
         hit      = 1'b1;
         hit_char = c;
      end else if (stack_op.code != css_ts_pkg::CLOSER_NONE) begin
         // An opener is dropped once the stack is full.
         stack_op.push = (eff_depth != DEPTH_BITS'(STACK_ENTRIES));
      end else if (eff_depth != '0) begin
         stack_op.pop = (close_code != css_ts_pkg::CLOSER_NONE) && (stack_top == close_code);
      end

      priority if (stack_op.push) begin
         new_depth = eff_depth + DEPTH_BITS'(1);
      end else if (stack_op.pop) begin
         new_depth = eff_depth - DEPTH_BITS'(1);
      end else begin
         new_depth = eff_depth;
      end
      depth_wide = 32'(new_depth);
      nest       = (depth_wide > 32'd255) ? 8'hFF : depth_wide[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= RSP_BITS'({nest, pos, hit_char, hit});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### sv/css_ts_checker.sv
`include "css_terminator_scanner_defines.svh"

module css_ts_checker #(
   parameter int POSITION_BITS = css_ts_pkg::POSITION_BITS_DEFAULT
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [((POSITION_BITS+17+7)/8)*8-1:0] rsp_tdata
);

   localparam int NEST_LSB = POSITION_BITS + 9;

   logic                                hit;
   logic [css_ts_pkg::NEST_BITS-1:0]    nest;

   assign hit  = rsp_tdata[0];
   assign nest = rsp_tdata[NEST_LSB+css_ts_pkg::NEST_BITS-1:NEST_LSB];

   // No result is shown in the cycle after reset.
   `CSS_TS_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "result valid after reset")

   // A stalled result is held unchanged.
   `CSS_TS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // The input side only stalls while a result waits at the output.
   `CSS_TS_ASSERT(a_ready_only_on_stall, clock, reset, !req_tready, rsp_tvalid && !rsp_tready, "input stalled without output back-pressure")

   // A hit is only found at depth zero, and the hit byte leaves the stack alone.
   `CSS_TS_ASSERT(a_hit_depth_zero, clock, reset, rsp_tvalid && hit, nest == '0, "hit reported inside brackets")

endmodule

bind css_terminator_scanner css_ts_checker #(
   .POSITION_BITS (POSITION_BITS)
) u_css_ts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
